[rtl/aeg_pkg.sv]
// ----------------------------------------------------------------------------
// aeg_pkg: shared types and constants of the ADSR envelope gain block
// Widths, segment and register codes, and the word that moves down the
// divider chain.
// ----------------------------------------------------------------------------
`default_nettype none

package aeg_pkg;

	localparam int LEN_W  = 24;           // width of one segment length
	localparam int IDX_W  = 31;           // sample index width
	localparam int SMP_W  = 16;           // audio sample width
	localparam int GAIN_W = 17;           // gain width, Q0.16 plus the unity bit
	localparam int SEG_W  = 3;
	localparam int QUO_W  = 16;           // quotient bits, one per divider cell
	localparam int NUM_W  = LEN_W + 2;    // high part of the dividend
	localparam int DIV_W  = LEN_W + 3;    // divisor, up to five times a length
	localparam int CMP_W  = ((LEN_W + 2) > IDX_W) ? (LEN_W + 3) : (IDX_W + 1);
	localparam int CFG_IDX_W = 2;

	localparam logic [GAIN_W-1:0] GAIN_ONE     = GAIN_W'(65536);
	localparam logic [GAIN_W-1:0] GAIN_SUSTAIN = GAIN_W'(52428);

	localparam logic [LEN_W-1:0] ATK_RESET = LEN_W'(441);
	localparam logic [LEN_W-1:0] DEC_RESET = LEN_W'(4410);
	localparam logic [LEN_W-1:0] SUS_RESET = LEN_W'(22050);
	localparam logic [LEN_W-1:0] REL_RESET = LEN_W'(4410);

	typedef enum logic [SEG_W-1:0] {
		SEG_ATTACK   = 3'd0,
		SEG_DECAY    = 3'd1,
		SEG_SUSTAIN  = 3'd2,
		SEG_RELEASE  = 3'd3,
		SEG_FINISHED = 3'd4
	} seg_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ATTACK  = 2'd0,
		REG_DECAY   = 2'd1,
		REG_SUSTAIN = 2'd2,
		REG_RELEASE = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [LEN_W-1:0] atk_len;
		logic [LEN_W-1:0] dec_len;
		logic [LEN_W-1:0] sus_len;
		logic [LEN_W-1:0] rel_len;
	} env_cfg_t;

	// One item in flight through the divider chain.
	typedef struct packed {
		logic                    valid;
		seg_t                    seg;
		logic signed [SMP_W-1:0] src;
		logic [DIV_W-1:0]        rem;
		logic [DIV_W-1:0]        dv;
		logic [QUO_W-1:0]        quo;
	} div_word_t;

endpackage

`default_nettype wire

[rtl/aeg_front.sv]
// ----------------------------------------------------------------------------
// aeg_front: segment selection
// Builds the segment boundaries over two stages, classifies the sample
// index and forms the dividend and divisor for the divider chain.
// ----------------------------------------------------------------------------
`default_nettype none

module aeg_front
	import aeg_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    accept,
	input  wire logic [IDX_W-1:0]        sample_index,
	input  wire logic signed [SMP_W-1:0] source_sample,
	input  wire env_cfg_t                cfg,
	output div_word_t                    word
);

	logic                    valid_s1, valid_s2, valid_s3, valid_s4;
	logic [IDX_W-1:0]        t_s1, t_s2, t_s3;
	logic signed [SMP_W-1:0] src_s1, src_s2, src_s3, src_s4;
	logic [LEN_W:0]          ad_s2, sr_s2;
	logic [LEN_W+1:0]        ad_s3, ads_s3, adsr_s3;
	seg_t                    seg_s4;
	logic [NUM_W-1:0]        num_s4;
	logic [DIV_W-1:0]        dv_s4;

	logic [CMP_W-1:0] t_x, a_x, ad_x, ads_x, adsr_x, dec_u, rel_u;
	seg_t             seg_d;
	logic [NUM_W-1:0] num_d;
	logic [DIV_W-1:0] dv_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		t_s1    <= sample_index;
		src_s1  <= source_sample;
		t_s2    <= t_s1;
		src_s2  <= src_s1;
		ad_s2   <= (LEN_W+1)'(cfg.atk_len) + (LEN_W+1)'(cfg.dec_len);
		sr_s2   <= (LEN_W+1)'(cfg.sus_len) + (LEN_W+1)'(cfg.rel_len);
		t_s3    <= t_s2;
		src_s3  <= src_s2;
		ad_s3   <= (LEN_W+2)'(ad_s2);
		ads_s3  <= (LEN_W+2)'(ad_s2) + (LEN_W+2)'(cfg.sus_len);
		adsr_s3 <= (LEN_W+2)'(ad_s2) + (LEN_W+2)'(sr_s2);
		src_s4  <= src_s3;
		seg_s4  <= seg_d;
		num_s4  <= num_d;
		dv_s4   <= dv_d;
	end

	// Boundaries are compared at a common width so no sum ever wraps.
	always_comb begin
		t_x    = CMP_W'(t_s3);
		a_x    = CMP_W'(cfg.atk_len);
		ad_x   = CMP_W'(ad_s3);
		ads_x  = CMP_W'(ads_s3);
		adsr_x = CMP_W'(adsr_s3);
		dec_u  = t_x - a_x;
		rel_u  = adsr_x - t_x;
		seg_d  = SEG_FINISHED;
		num_d  = '0;
		dv_d   = '0;
		if (t_x < a_x) begin
			seg_d = SEG_ATTACK;
			num_d = NUM_W'(t_s3[LEN_W-1:0]);
			dv_d  = DIV_W'(cfg.atk_len);
		end else if (t_x < ad_x) begin
			seg_d = SEG_DECAY;
			num_d = NUM_W'(dec_u[LEN_W-1:0]);
			dv_d  = DIV_W'({cfg.dec_len, 2'b00}) + DIV_W'(cfg.dec_len);
		end else if (t_x < ads_x) begin
			seg_d = SEG_SUSTAIN;
		end else if (t_x < adsr_x) begin
			// Remaining release length times four over five lengths.
			seg_d = SEG_RELEASE;
			num_d = {rel_u[LEN_W-1:0], 2'b00};
			dv_d  = DIV_W'({cfg.rel_len, 2'b00}) + DIV_W'(cfg.rel_len);
		end
	end

	always_comb begin
		word.valid = valid_s4;
		word.seg   = seg_s4;
		word.src   = src_s4;
		word.rem   = DIV_W'(num_s4);
		word.dv    = dv_s4;
		word.quo   = '0;
	end

endmodule

`default_nettype wire

[rtl/aeg_div_cell.sv]
// ----------------------------------------------------------------------------
// aeg_div_cell: one cell of the divider chain
// Resolves one quotient bit by restoring division and passes the word on.
// ----------------------------------------------------------------------------
`default_nettype none

module aeg_div_cell
	import aeg_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire div_word_t word_in,
	output div_word_t      word_out
);

	div_word_t        word_q;
	logic [DIV_W:0]   rem_sh;
	logic             ge;
	logic [DIV_W:0]   rem_sub;

	// The low dividend bits are all zero, so a zero is shifted in.
	always_comb begin
		rem_sh  = {word_in.rem, 1'b0};
		ge      = rem_sh >= (DIV_W+1)'(word_in.dv);
		rem_sub = rem_sh - (DIV_W+1)'(word_in.dv);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else begin
			word_q.valid <= word_in.valid;
			word_q.seg   <= word_in.seg;
			word_q.src   <= word_in.src;
			word_q.dv    <= word_in.dv;
			word_q.rem   <= ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
			word_q.quo   <= {word_in.quo[QUO_W-2:0], ge};
		end
	end

	assign word_out = word_q;

endmodule

`default_nettype wire

[rtl/aeg_tail.sv]
// ----------------------------------------------------------------------------
// aeg_tail: gain formation and sample scaling
// Turns the quotient into the segment gain, then multiplies the sample.
// ----------------------------------------------------------------------------
`default_nettype none

module aeg_tail
	import aeg_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire div_word_t           word,
	output logic                     done,
	output logic signed [SMP_W-1:0]  scaled_sample,
	output logic [GAIN_W-1:0]        envelope_gain,
	output logic [SEG_W-1:0]         segment
);

	logic                          valid_s1, valid_s2;
	seg_t                          seg_s1, seg_s2;
	logic signed [SMP_W-1:0]       src_s1, scaled_s2;
	logic [GAIN_W-1:0]             gain_s1, gain_s2;
	logic [GAIN_W-1:0]             gain_d;
	logic signed [SMP_W+GAIN_W:0]  prod;

	always_comb begin
		case (word.seg)
			SEG_ATTACK:  gain_d = GAIN_W'(word.quo);
			SEG_DECAY:   gain_d = GAIN_ONE - GAIN_W'(word.quo);
			SEG_SUSTAIN: gain_d = GAIN_SUSTAIN;
			SEG_RELEASE: gain_d = GAIN_W'(word.quo);
			default:     gain_d = '0;
		endcase
	end

	// Signed sample times non-negative gain; bits above 16 give the floor.
	assign prod = src_s1 * $signed({1'b0, gain_s1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= word.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		seg_s1    <= word.seg;
		src_s1    <= word.src;
		gain_s1   <= gain_d;
		seg_s2    <= seg_s1;
		gain_s2   <= gain_s1;
		scaled_s2 <= prod[SMP_W+15:16];
	end

	assign done          = valid_s2;
	assign scaled_sample = scaled_s2;
	assign envelope_gain = gain_s2;
	assign segment       = seg_s2;

endmodule

`default_nettype wire

[rtl/adsr_envelope_gain_top.sv]
// ----------------------------------------------------------------------------
// adsr_envelope_gain_top: linear ADSR envelope applied to an audio stream
// Each word carries a sample index and one sample; the block returns the
// sample scaled by the envelope gain, the gain and the segment.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  -------   --------------------   -----------------------------------------
//  input     start / busy           sample_index, source_sample
//  config    cfg_valid / cfg_ready  cfg_index, cfg_wdata
//  result    done (one-cycle)       scaled_sample, envelope_gain, segment
//
// A new word may be started in every clock cycle; busy stays low. The result
// for a word is strobed by done, and results leave in the order the words
// came in. Between them lie four stages of segment selection, the divider
// chain of sixteen cells, one quotient bit each, and two stages of gain and
// multiply after it.
// The receiver cannot stall; every result is shown for exactly one cycle.
// Reset returns the four segment lengths to their default values and empties
// the pipeline; results in flight are dropped.
//
// Segment lengths are counted in samples, so the sample rate never enters
// the arithmetic. The front compares the index against running sums of the
// lengths, which are built at full width and cannot wrap. A zero-length
// segment never matches and is therefore never used as a divisor. The gain
// is unsigned Q1.16: t/A in attack, 1 - u/(5D) in decay, a
// fixed 0.8 in sustain and 4(R-u)/(5R) in release. Every quotient is below
// one, so each divider cell only needs to settle one bit of it.
//
// Configuration words may only arrive while no word is in flight. The
// lengths are read directly by the pipeline, so a word started in the cycle
// after a write already sees the new value.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_envelope_gain_top
	import aeg_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// input words
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [IDX_W-1:0]        sample_index,
	input  wire logic signed [SMP_W-1:0] source_sample,
	// configuration writes
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [LEN_W-1:0]        cfg_wdata,
	// result words
	output logic                         done,
	output logic signed [SMP_W-1:0]      scaled_sample,
	output logic [GAIN_W-1:0]            envelope_gain,
	output logic [SEG_W-1:0]             segment
);

	env_cfg_t  cfg_q;
	logic      accept;
	div_word_t chain [QUO_W+1];

	// The pipeline never holds off an input word or a configuration write.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Configuration registers. Every index names a register, so no write
	// is lost; each write replaces one length as a whole.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.atk_len <= ATK_RESET;
			cfg_q.dec_len <= DEC_RESET;
			cfg_q.sus_len <= SUS_RESET;
			cfg_q.rel_len <= REL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				REG_ATTACK:  cfg_q.atk_len <= cfg_wdata;
				REG_DECAY:   cfg_q.dec_len <= cfg_wdata;
				REG_SUSTAIN: cfg_q.sus_len <= cfg_wdata;
				REG_RELEASE: cfg_q.rel_len <= cfg_wdata;
				default:     cfg_q         <= cfg_q;
			endcase
		end
	end

	// Segment selection: finds the segment and sets up numerator and divisor.
	aeg_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.sample_index  (sample_index),
		.source_sample (source_sample),
		.cfg           (cfg_q),
		.word          (chain[0])
	);

	// The divider: a row of identical cells, each settling one quotient bit
	// (most significant first) and handing the word to its neighbor.
	for (genvar k = 0; k < QUO_W; k++) begin : g_cell
		aeg_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.word_in  (chain[k]),
			.word_out (chain[k+1])
		);
	end

	// Gain per segment, the multiply, and the result register.
	aeg_tail u_tail (
		.clk           (clk),
		.arst_n        (arst_n),
		.word          (chain[QUO_W]),
		.done          (done),
		.scaled_sample (scaled_sample),
		.envelope_gain (envelope_gain),
		.segment       (segment)
	);

endmodule

`default_nettype wire

[test/adsr_envelope_gain_top_tb.sv]
// ----------------------------------------------------------------------------
// adsr_envelope_gain_top_tb: self-checking bench for the ADSR envelope gain
// Words with a sample index and one audio sample are pushed through the block
// under several sets of segment lengths. A behavioral envelope computes the
// gain, the segment and the scaled sample for each accepted word, and every
// result strobe is checked against the oldest pending prediction.
// ----------------------------------------------------------------------------

module adsr_envelope_gain_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import aeg_pkg::*;

	// The end-of-run wait covers the pipeline latency and adds a margin on
	// top of it. The watchdog allows long random sender gaps.
	localparam int PIPE_LATENCY  = 21;
	localparam int QUIET_LIMIT   = 1000;
	localparam int REPORT_LIMIT  = 10;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_WORDS   = 50;

	localparam logic [IDX_W-1:0] INDEX_MAX = {IDX_W{1'b1}};
	localparam logic [LEN_W-1:0] LENGTH_MAX = {LEN_W{1'b1}};

	// One predicted result word.
	typedef struct packed {
		logic signed [SMP_W-1:0] scaled;
		logic [GAIN_W-1:0]       gain;
		seg_t                    seg;
	} env_word_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [IDX_W-1:0]        sample_index;
	logic signed [SMP_W-1:0] source_sample;
	logic                    cfg_valid;
	logic                    cfg_ready;
	cfg_idx_t                cfg_index;
	logic [LEN_W-1:0]        cfg_wdata;
	logic                    done;
	logic signed [SMP_W-1:0] scaled_sample;
	logic [GAIN_W-1:0]       envelope_gain;
	logic [SEG_W-1:0]        segment;

	// The bench's own copy of the four segment lengths, updated as each
	// configuration word is accepted.
	env_cfg_t  seg_lengths;
	env_word_t pending_results[$];
	env_word_t due_word;

	int sender_idle_pct;
	int mismatch_count;
	int words_checked;
	int length_settings;
	int length_writes;
	int seg_seen [5];

	adsr_envelope_gain_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.sample_index  (sample_index),
		.source_sample (source_sample),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.done          (done),
		.scaled_sample (scaled_sample),
		.envelope_gain (envelope_gain),
		.segment       (segment)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Envelope predictor. Segment boundaries are running sums of the four
	// lengths taken at 64 bits, so they cannot wrap. A zero-length segment
	// has an empty range and is never used as a divisor.
	// ------------------------------------------------------------------
	function automatic env_word_t envelope_of(logic [IDX_W-1:0] t_in,
			logic signed [SMP_W-1:0] src);
		env_word_t        res;
		longint unsigned  t;
		longint unsigned  end_atk;
		longint unsigned  end_dec;
		longint unsigned  end_sus;
		longint unsigned  end_rel;
		longint unsigned  dec_len;
		longint unsigned  rel_len;
		longint unsigned  u;
		longint unsigned  g;
		longint           src_wide;
		longint           product;
		t       = t_in;
		dec_len = seg_lengths.dec_len;
		rel_len = seg_lengths.rel_len;
		end_atk = seg_lengths.atk_len;
		end_dec = end_atk + dec_len;
		end_sus = end_dec + seg_lengths.sus_len;
		end_rel = end_sus + rel_len;
		if (t < end_atk) begin
			// Ramp from zero toward one.
			g = (t << 16) / end_atk;
			res.seg = SEG_ATTACK;
		end else if (t < end_dec) begin
			// Fall from one toward 0.8, dividing by five times the decay length.
			u = t - end_atk;
			g = 64'd65536 - ((u << 16) / (5 * dec_len));
			res.seg = SEG_DECAY;
		end else if (t < end_sus) begin
			g = 64'd52428;
			res.seg = SEG_SUSTAIN;
		end else if (t < end_rel) begin
			// Fall from 0.8 toward zero.
			u = t - end_sus;
			g = ((4 * (rel_len - u)) << 16) / (5 * rel_len);
			res.seg = SEG_RELEASE;
		end else begin
			g = 0;
			res.seg = SEG_FINISHED;
		end
		// The product is floored, so negative samples round toward minus
		// infinity; an arithmetic shift gives exactly that.
		src_wide = src;
		product  = src_wide * $signed(g);
		res.scaled = SMP_W'(product >>> 16);
		res.gain   = GAIN_W'(g);
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Random stimulus helpers.
	// ------------------------------------------------------------------

	// Lengths lean toward small values so that random indexes land in
	// every segment, with zero, one and the full range mixed in.
	function automatic logic [LEN_W-1:0] random_length();
		int pick;
		pick = $urandom_range(99);
		if (pick < 10)
			return '0;
		else if (pick < 20)
			return LEN_W'(1);
		else if (pick < 40)
			return LEN_W'($urandom_range(16, 2));
		else if (pick < 65)
			return LEN_W'($urandom_range(300, 2));
		else if (pick < 80)
			return LEN_W'($urandom_range(70000, 2));
		else if (pick < 90)
			return LEN_W'($urandom);
		else
			return LENGTH_MAX;
	endfunction

	// Most indexes target one segment, often its first or last sample;
	// the rest are raw 31-bit values or the two extremes.
	function automatic logic [IDX_W-1:0] random_index();
		longint unsigned bound [5];
		longint unsigned span;
		int              pick;
		int              k;
		bound[0] = 0;
		bound[1] = seg_lengths.atk_len;
		bound[2] = bound[1] + seg_lengths.dec_len;
		bound[3] = bound[2] + seg_lengths.sus_len;
		bound[4] = bound[3] + seg_lengths.rel_len;
		pick = $urandom_range(99);
		if (pick < 8)
			return IDX_W'($urandom);
		if (pick < 12)
			return pick[0] ? INDEX_MAX : '0;
		k = $urandom_range(4);
		span = (k == 4) ? 64'd1000 : bound[k+1] - bound[k];
		if (span == 0)
			return IDX_W'(bound[k]);
		case ($urandom_range(3))
			0: begin
				return IDX_W'(bound[k]);
			end
			1: begin
				return IDX_W'(bound[k] + span - 1);
			end
			default: begin
				return IDX_W'(bound[k] + $urandom_range(32'(span - 1)));
			end
		endcase
	endfunction

	function automatic logic signed [SMP_W-1:0] random_sample();
		case ($urandom_range(19))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			3: return 16'shffff;
			default: return SMP_W'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Drivers. Everything changes on the falling edge; handshakes are
	// judged on the rising edge. Both tasks leave their valid or start high
	// so that back-to-back words never lower and raise it in one step.
	// ------------------------------------------------------------------

	task automatic send_word(logic [IDX_W-1:0] t, logic signed [SMP_W-1:0] src);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start         <= 1'b1;
		sample_index  <= t;
		source_sample <= src;
		do
			@(posedge clk);
		while (busy);
		pending_results.push_back(envelope_of(t, src));
		@(negedge clk);
	endtask

	task automatic end_words();
		start <= 1'b0;
	endtask

	// Every word yields a result, so an empty prediction queue means the
	// pipeline has nothing left in flight.
	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_length(cfg_idx_t idx, logic [LEN_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_ATTACK: begin
				seg_lengths.atk_len = value;
			end
			REG_DECAY: begin
				seg_lengths.dec_len = value;
			end
			REG_SUSTAIN: begin
				seg_lengths.sus_len = value;
			end
			default: begin
				seg_lengths.rel_len = value;
			end
		endcase
		length_writes++;
		@(negedge clk);
	endtask

	// Lengths only change while the block is idle; the caller has already
	// lowered start.
	task automatic set_lengths(logic [LEN_W-1:0] atk, logic [LEN_W-1:0] dec,
			logic [LEN_W-1:0] sus, logic [LEN_W-1:0] rel);
		wait_drained();
		write_length(REG_ATTACK, atk);
		write_length(REG_DECAY, dec);
		write_length(REG_SUSTAIN, sus);
		write_length(REG_RELEASE, rel);
		cfg_valid <= 1'b0;
		length_settings++;
	endtask

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// Reset lengths: first and last sample of each segment, the largest
	// index, and both ends of the sample range.
	task automatic test_default_lengths();
		send_word(31'd0, 16'sh7fff);
		send_word(31'd220, 16'sh0000);
		send_word(31'd440, 16'sh8000);
		send_word(31'd441, 16'sh7fff);
		send_word(31'd441, 16'sh8000);
		send_word(31'd4850, 16'sd12345);
		send_word(31'd4851, 16'shffff);
		send_word(31'd26900, 16'sd1);
		send_word(31'd26901, 16'sh7fff);
		send_word(31'd31310, 16'sh8000);
		send_word(31'd31311, 16'sh7fff);
		send_word(INDEX_MAX, 16'sh8000);
		end_words();
	endtask

	// Zero-length segments are skipped: with all four empty every word is
	// finished, and a lone decay must be reached straight from index zero.
	task automatic test_zero_lengths();
		set_lengths('0, '0, '0, '0);
		send_word(31'd0, 16'sh7fff);
		send_word(INDEX_MAX, 16'sh8000);
		end_words();
		set_lengths('0, LEN_W'(3), '0, '0);
		send_word(31'd0, 16'sh8000);
		send_word(31'd3, 16'sh7fff);
		end_words();
	endtask

	// Full-range lengths push the boundary sums past 24 bits.
	task automatic test_max_lengths();
		set_lengths(LENGTH_MAX, LENGTH_MAX, LENGTH_MAX, LENGTH_MAX);
		send_word(31'd16777214, 16'sh7fff);
		send_word(31'd16777215, 16'sh8000);
		send_word(31'd33554429, 16'sh7fff);
		send_word(31'd67108859, 16'sh8000);
		send_word(31'd67108860, 16'sh7fff);
		send_word(INDEX_MAX, 16'sh7fff);
		end_words();
	endtask

	// One-sample segments: each index from zero on lands in the next one.
	task automatic test_unit_lengths();
		set_lengths(LEN_W'(1), LEN_W'(1), LEN_W'(1), LEN_W'(1));
		for (int t = 0; t < 5; t++)
			send_word(IDX_W'(t), random_sample());
		end_words();
	endtask

	// Random lengths per phase, random words within; the sender's idling
	// runs at 33 percent, then 75, then not at all.
	task automatic test_random_lengths();
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			sender_idle_pct = (phase < 4) ? 33 : (phase < 8) ? 75 : 0;
			set_lengths(random_length(), random_length(), random_length(),
				random_length());
			repeat (PHASE_WORDS)
				send_word(random_index(), random_sample());
			end_words();
		end
	endtask

	// ------------------------------------------------------------------
	// Result checking. The receiver cannot stall, so every done strobe is a
	// word to be matched against the oldest prediction.
	// ------------------------------------------------------------------

	task automatic flag_mismatch(string what, longint exp_val, longint act_val);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%0t: %s mismatch: expected %0d, got %0d",
				$realtime, what, exp_val, act_val);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("unexpected result word, segment", -1, segment);
			end else begin
				due_word = pending_results.pop_front();
				words_checked++;
				seg_seen[due_word.seg]++;
				if (scaled_sample !== due_word.scaled)
					flag_mismatch("scaled_sample", due_word.scaled, scaled_sample);
				if (envelope_gain !== due_word.gain)
					flag_mismatch("envelope_gain", due_word.gain, envelope_gain);
				if (segment !== due_word.seg)
					flag_mismatch("segment", due_word.seg, segment);
			end
		end
	end

	// Watchdog: ends the run if no word of any kind moves for too long.
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Watchdog expired after %0d quiet cycles", QUIET_LIMIT);
		$display("FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------
	initial begin
		int leftover;
		arst_n          = 1'b0;
		start           = 1'b0;
		sample_index    = '0;
		source_sample   = '0;
		cfg_valid       = 1'b0;
		cfg_index       = REG_ATTACK;
		cfg_wdata       = '0;
		sender_idle_pct = 0;
		mismatch_count  = 0;
		words_checked   = 0;
		length_settings = 1;
		length_writes   = 0;
		foreach (seg_seen[i])
			seg_seen[i] = 0;
		seg_lengths = '{atk_len: ATK_RESET, dec_len: DEC_RESET,
			sus_len: SUS_RESET, rel_len: REL_RESET};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_default_lengths();
		test_zero_lengths();
		test_max_lengths();
		test_unit_lengths();
		test_random_lengths();

		// Let the pipeline empty, then watch a little longer for strays.
		wait_drained();
		repeat (PIPE_LATENCY + 8) @(posedge clk);
		leftover = pending_results.size();
		if (leftover != 0)
			$display("%0d predicted result words never arrived", leftover);

		$display("Checked %0d result words under %0d length settings (%0d register writes).",
			words_checked, length_settings, length_writes);
		$display("Per segment: attack %0d, decay %0d, sustain %0d, release %0d, finished %0d.",
			seg_seen[0], seg_seen[1], seg_seen[2], seg_seen[3], seg_seen[4]);
		if (mismatch_count == 0 && leftover == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
